// ===== design/ica_pkg.sv =====
`default_nettype none
package ica_pkg;
    localparam int unsigned W = 32;
    // Divider layout: quotient bits resolved per stage, and stage count.
    localparam int unsigned DIV_BITS   = 4;
    localparam int unsigned DIV_STAGES = W / DIV_BITS;

    typedef enum logic [4:0] {
        OP_NEG = 5'd0, OP_NOT = 5'd1, OP_LNOT = 5'd2, OP_ADD = 5'd3, OP_SUB = 5'd4,
        OP_MUL = 5'd5, OP_UDIV = 5'd6, OP_SDIV = 5'd7, OP_SREM = 5'd8, OP_SMOD = 5'd9,
        OP_UMOD = 5'd10, OP_SRL = 5'd11, OP_SRA = 5'd12, OP_SLL = 5'd13, OP_OR = 5'd14,
        OP_AND = 5'd15, OP_XOR = 5'd16, OP_LEQ = 5'd17, OP_LNE = 5'd18, OP_LOR = 5'd19,
        OP_LAND = 5'd20, OP_EQ = 5'd21, OP_NE = 5'd22, OP_ULT = 5'd23, OP_SLT = 5'd24,
        OP_UGT = 5'd25, OP_SGT = 5'd26, OP_ULE = 5'd27, OP_SLE = 5'd28, OP_UGE = 5'd29,
        OP_SGE = 5'd30, OP_SEL = 5'd31
    } t_op;

    // Per-stage payload carried through the pipe.
    typedef struct packed {
        t_op          op;
        logic [W-1:0] a;     // divisor (magnitude for signed ops)
        logic [W-1:0] b;
        logic [W-1:0] rem;   // partial remainder
        logic [W-1:0] quo;   // dividend shifting out / quotient shifting in
        logic [W-1:0] res;   // result of non-divide ops
        logic         dz;
        logic         neg_q;
        logic         neg_r;
    } t_stage;
endpackage
`default_nettype wire

// ===== design/ica_front.sv =====
`default_nettype none
// Entry stage: decode, simple ops, divider operand preparation.
module ica_front (
    input  wire logic [4:0]             i_kind,
    input  wire logic [ica_pkg::W-1:0]  i_a,
    input  wire logic [ica_pkg::W-1:0]  i_b,
    input  wire logic [ica_pkg::W-1:0]  i_c,
    output ica_pkg::t_stage             o_st
);
    localparam int unsigned W = ica_pkg::W;
    logic ta, tb, sa, sb, ult, slt, big;
    logic [W-1:0] maga, magb, sh, res;
    logic [4:0] amt;
    ica_pkg::t_op op;
    logic is_div, sgn;

    always_comb begin
        op   = ica_pkg::t_op'(i_kind);
        ta   = |i_a;
        tb   = |i_b;
        sa   = i_a[W-1];
        sb   = i_b[W-1];
        ult  = i_a < i_b;
        slt  = $signed(i_a) < $signed(i_b);
        big  = |i_b[W-1:5];
        amt  = i_b[4:0];
        maga = sa ? (W'(0) - i_a) : i_a;
        magb = sb ? (W'(0) - i_b) : i_b;
        sh   = '0;
        case (op)
            ica_pkg::OP_SRL: sh = big ? '0 : (i_a >> amt);
            ica_pkg::OP_SRA: sh = big ? {W{sa}} : W'($signed(i_a) >>> amt);
            ica_pkg::OP_SLL: sh = big ? '0 : (i_a << amt);
            default:         sh = '0;
        endcase
        res = '0;
        case (op)
            ica_pkg::OP_NEG:  res = W'(0) - i_a;
            ica_pkg::OP_NOT:  res = ~i_a;
            ica_pkg::OP_LNOT: res = W'(!ta);
            ica_pkg::OP_ADD:  res = i_a + i_b;
            ica_pkg::OP_SUB:  res = i_a - i_b;
            ica_pkg::OP_SRL, ica_pkg::OP_SRA, ica_pkg::OP_SLL: res = sh;
            ica_pkg::OP_OR:   res = i_a | i_b;
            ica_pkg::OP_AND:  res = i_a & i_b;
            ica_pkg::OP_XOR:  res = i_a ^ i_b;
            ica_pkg::OP_LEQ:  res = W'(ta == tb);
            ica_pkg::OP_LNE:  res = W'(ta != tb);
            ica_pkg::OP_LOR:  res = W'(ta || tb);
            ica_pkg::OP_LAND: res = W'(ta && tb);
            ica_pkg::OP_EQ:   res = W'(i_a == i_b);
            ica_pkg::OP_NE:   res = W'(i_a != i_b);
            ica_pkg::OP_ULT:  res = W'(ult);
            ica_pkg::OP_SLT:  res = W'(slt);
            ica_pkg::OP_UGT:  res = W'(!ult && (i_a != i_b));
            ica_pkg::OP_SGT:  res = W'(!slt && (i_a != i_b));
            ica_pkg::OP_ULE:  res = W'(ult || (i_a == i_b));
            ica_pkg::OP_SLE:  res = W'(slt || (i_a == i_b));
            ica_pkg::OP_UGE:  res = W'(!ult);
            ica_pkg::OP_SGE:  res = W'(!slt);
            ica_pkg::OP_SEL:  res = ta ? i_b : i_c;
            default:          res = '0;
        endcase
        is_div = (op == ica_pkg::OP_UDIV) || (op == ica_pkg::OP_SDIV) ||
                 (op == ica_pkg::OP_SREM) || (op == ica_pkg::OP_SMOD) ||
                 (op == ica_pkg::OP_UMOD);
        sgn = (op == ica_pkg::OP_SDIV) || (op == ica_pkg::OP_SREM) ||
              (op == ica_pkg::OP_SMOD);
        o_st.op    = op;
        o_st.b     = i_b;
        o_st.rem   = '0;
        o_st.quo   = sgn ? maga : i_a;
        o_st.res   = res;
        o_st.dz    = is_div && !tb;
        o_st.neg_q = sgn && (sa ^ sb);
        o_st.neg_r = sgn && sa;
        // divisor magnitude travels in a for signed ops; original b kept for modulo fixup
        o_st.a     = sgn ? magb : i_b;
    end
endmodule
`default_nettype wire

// ===== design/ica_div_step.sv =====
`default_nettype none
// Restoring divide: DIV_BITS quotient bits per pipeline stage.
module ica_div_step (
    input  wire ica_pkg::t_stage i_st,
    output ica_pkg::t_stage      o_st
);
    localparam int unsigned W = ica_pkg::W;
    logic [W-1:0] r, q;
    logic [W:0]   t;

    always_comb begin
        r = i_st.rem;
        q = i_st.quo;
        t = '0;
        for (int k = 0; k < ica_pkg::DIV_BITS; k++) begin
            t = {r, q[W-1]};
            q = {q[W-2:0], 1'b0};
            if (t >= {1'b0, i_st.a}) begin
                t    = t - {1'b0, i_st.a};
                q[0] = 1'b1;
            end
            r = t[W-1:0];
        end
        o_st     = i_st;
        o_st.rem = r;
        o_st.quo = q;
    end
endmodule
`default_nettype wire

// ===== design/ica_back.sv =====
`default_nettype none
// Final stage: sign fixup, modulo correction, result select.
module ica_back (
    input  wire ica_pkg::t_stage       i_st,
    input  wire logic [ica_pkg::W-1:0] i_prod,
    output logic [ica_pkg::W-1:0]  o_res,
    output logic                   o_dz
);
    localparam int unsigned W = ica_pkg::W;
    logic [W-1:0] q, r;

    always_comb begin
        q = i_st.neg_q ? (W'(0) - i_st.quo) : i_st.quo;
        r = i_st.neg_r ? (W'(0) - i_st.rem) : i_st.rem;
        o_dz = i_st.dz;
        case (i_st.op)
            ica_pkg::OP_MUL:  o_res = i_prod;
            ica_pkg::OP_UDIV, ica_pkg::OP_SDIV: o_res = q;
            ica_pkg::OP_SREM, ica_pkg::OP_UMOD: o_res = r;
            ica_pkg::OP_SMOD: o_res = ((r != '0) && (r[W-1] ^ i_st.b[W-1])) ?
                                      r + i_st.b : r;
            default:          o_res = i_st.res;
        endcase
        if (i_st.dz) o_res = '0;
    end
endmodule
`default_nettype wire

// ===== design/integer_constant_alu.sv =====
`default_nettype none
// 32-bit integer ALU, 32 operations selected by kind (negate .. select).
// Fully pipelined: one request accepted per cycle while not stalled, results
// in order. The pipe is ten register stages deep (one entry register, eight
// restoring-divide stages of four quotient bits each, one fixup/output
// register). The divider stages set the depth; multiply is registered
// alongside. Backpressure stalls the whole pipe in place (global enable), so
// nothing is lost or repeated. A zero divisor on any divide or remainder
// kind gives 0 with divide_by_zero set.
module integer_constant_alu (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    input  wire logic [95:0]   s_axis_tdata,  // operand_a, operand_b, operand_c
    input  wire logic [4:0]    s_axis_tuser,  // kind
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    output logic [39:0]        m_axis_tdata,  // result_word, divide_by_zero, zero pad
    output logic [0:0]         m_axis_tuser   // unused, zero
);
    localparam int unsigned W = ica_pkg::W;
    localparam int unsigned NS = ica_pkg::DIV_STAGES;

    logic en;
    ica_pkg::t_stage fr;
    ica_pkg::t_stage r_st [NS+1];
    ica_pkg::t_stage n_st [NS];
    logic [NS:0] r_v;
    logic [W-1:0] r_prod0, r_prod [NS];
    logic [W-1:0] fin_res;
    logic fin_dz, r_odz;
    logic [W-1:0] r_ores;
    logic r_ov;

    assign en = !r_ov || m_axis_tready;
    assign s_axis_tready = en;

    ica_front u_front (
        .i_kind(s_axis_tuser), .i_a(s_axis_tdata[31:0]), .i_b(s_axis_tdata[63:32]),
        .i_c(s_axis_tdata[95:64]), .o_st(fr)
    );

    for (genvar g = 0; g < NS; g++) begin : g_div
        ica_div_step u_step (.i_st(r_st[g]), .o_st(n_st[g]));
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_st[0] <= fr;
            r_prod0 <= s_axis_tdata[31:0] * s_axis_tdata[63:32];
            r_prod[0] <= r_prod0;
            for (int k = 0; k < NS; k++) r_st[k+1] <= n_st[k];
            for (int k = 1; k < NS; k++) r_prod[k] <= r_prod[k-1];
            r_ores <= fin_res;
            r_odz  <= fin_dz;
        end
        if (!i_rst_n) begin
            r_v  <= '0;
            r_ov <= 1'b0;
        end else if (en) begin
            r_v  <= {r_v[NS-1:0], s_axis_tvalid};
            r_ov <= r_v[NS];
        end
    end

    // product taps sit level with the last divide stage
    ica_back u_back (.i_st(r_st[NS]), .i_prod(r_prod[NS-1]), .o_res(fin_res), .o_dz(fin_dz));

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {7'd0, r_odz, r_ores};
    assign m_axis_tuser  = 1'b0;

`ifndef NO_ASSERTIONS
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed under stall");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready) else $error("stall with empty output");
    a_dz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[32] |-> m_axis_tdata[31:0] == '0)
        else $error("dz with nonzero result");
`endif
endmodule
`default_nettype wire
